[design/scft_pkg.sv]
// ----------------------------------------------------------------------------
// scft_pkg
// Shared widths, limits and the divider status type for the square-root
// continued fraction run-of-ones test.
// ----------------------------------------------------------------------------
package scft_pkg;

  localparam int CAND_W   = 31;
  localparam int CFG_W    = 8;
  localparam int PERIOD_W = 20;
  localparam int RUN_W    = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
  localparam logic [RUN_W-1:0]    RUN_MAX    = {RUN_W{1'b1}};
  localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(1);

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[design/scft_div.sv]
// ----------------------------------------------------------------------------
// scft_div
// Restoring shift-subtract divider, one quotient bit per cycle. Shared by
// both divisions of every continued-fraction step.
// ----------------------------------------------------------------------------
module scft_div
  import scft_pkg::*;
#(
  parameter int NW = 31,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output div_sts_t      sts
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[design/sqrt_cfrac_ones_run_test_unit.sv]
// ----------------------------------------------------------------------------
// sqrt_cfrac_ones_run_test_unit
// Integer square root, then the periodic continued-fraction expansion of
// sqrt(k), tracking the longest run of partial quotients equal to one.
// ----------------------------------------------------------------------------
// One candidate is worked at a time. The integer root (KW = KEY_WIDTH, at
// most 31) is done by a shift-subtract loop. Each partial quotient of the
// period then passes through the multiplier states S_MULA and S_MULB and
// makes two passes through the shared bit-serial divider. A perfect square
// finishes after the root. The next candidate is taken once the result is
// in the output register, which holds it until it is transferred.
module sqrt_cfrac_ones_run_test_unit
  import scft_pkg::*;
#(
  parameter int KEY_WIDTH = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CAND_W-1:0]   in_candidate,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic                out_is_square,
  output logic [PERIOD_W-1:0] out_period_length,
  output logic [RUN_W-1:0]    out_longest_run,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data
);

  localparam int KW = (KEY_WIDTH < CAND_W) ? KEY_WIDTH : CAND_W;
  localparam int HW = (KW + 1) / 2;
  localparam int DW = HW + 1;
  localparam logic [KW-1:0] BIT_TOP = KW'(1) << (2 * (HW - 1));

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ROOT    = 4'd1;
  localparam logic [3:0] S_MULA    = 4'd2;
  localparam logic [3:0] S_MULB    = 4'd3;
  localparam logic [3:0] S_DZ_GO   = 4'd4;
  localparam logic [3:0] S_DZ_WAIT = 4'd5;
  localparam logic [3:0] S_DR_GO   = 4'd6;
  localparam logic [3:0] S_DR_WAIT = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;

  logic [KW-1:0]       k_r, k_nxt;
  logic [KW-1:0]       rem_r, rem_nxt;
  logic [KW-1:0]       root_r, root_nxt;
  logic [KW-1:0]       bit_r, bit_nxt;
  logic [HW-1:0]       x_r, x_nxt;
  logic [HW-1:0]       y_r, y_nxt;
  logic [DW-1:0]       z_r, z_nxt;
  logic [DW-1:0]       r_r, r_nxt;
  logic [KW-1:0]       num_r, num_nxt;
  logic                sq_r, sq_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [RUN_W-1:0]    best_r, best_nxt;

  logic                out_valid_r;
  logic                out_hit_r;
  logic                out_sq_r;
  logic [PERIOD_W-1:0] out_period_r;
  logic [RUN_W-1:0]    out_run_r;

  logic [DW-1:0]       mul_a, mul_b;
  logic [2*DW-1:0]     prod;
  logic [DW-1:0]       ydiff;
  logic [KW:0]         tsum;
  logic [DW-1:0]       xy_sum;
  logic [RUN_W-1:0]    run_inc;
  logic [DW-1:0]       quo_lo;

  logic                div_start;
  logic [KW-1:0]       div_num;
  logic [KW-1:0]       div_quo;
  div_sts_t            div_sts;

  logic                in_xfer, out_xfer, out_load;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);

  // one multiplier, shared by r*z and y*y
  assign mul_a  = (state_r == S_MULA) ? r_r : {1'b0, y_r};
  assign mul_b  = (state_r == S_MULA) ? z_r : {1'b0, y_r};
  assign prod   = mul_a * mul_b;
  assign ydiff  = prod[DW-1:0] - {1'b0, y_r};
  assign tsum   = {1'b0, root_r} + {1'b0, bit_r};
  assign xy_sum = {1'b0, x_r} + {1'b0, y_r};
  assign quo_lo = div_quo[DW-1:0];
  assign run_inc = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);

  assign div_start = (state_r == S_DZ_GO) || (state_r == S_DR_GO);
  assign div_num   = (state_r == S_DR_GO) ? {{(KW - DW){1'b0}}, xy_sum} : num_r;

  scft_div #(
    .NW (KW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (z_r),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    r_nxt      = r_r;
    num_nxt    = num_r;
    sq_nxt     = sq_r;
    period_nxt = period_r;
    run_nxt    = run_r;
    best_nxt   = best_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          k_nxt      = in_candidate[KW-1:0];
          rem_nxt    = in_candidate[KW-1:0];
          root_nxt   = '0;
          bit_nxt    = BIT_TOP;
          sq_nxt     = 1'b0;
          period_nxt = '0;
          run_nxt    = '0;
          best_nxt   = '0;
          state_nxt  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (bit_r == '0) begin
          x_nxt = root_r[HW-1:0];
          y_nxt = root_r[HW-1:0];
          z_nxt = DW'(1);
          r_nxt = {root_r[HW-1:0], 1'b0};
          if (rem_r == '0) begin
            sq_nxt    = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_MULA;
          end
        end else begin
          if ({1'b0, rem_r} >= tsum) begin
            rem_nxt  = rem_r - tsum[KW-1:0];
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      S_MULA: begin
        y_nxt     = ydiff[HW-1:0];
        state_nxt = S_MULB;
      end
      S_MULB: begin
        num_nxt   = k_r - prod[KW-1:0];
        state_nxt = S_DZ_GO;
      end
      S_DZ_GO: begin
        state_nxt = S_DZ_WAIT;
      end
      S_DZ_WAIT: begin
        if (div_sts.done) begin
          z_nxt     = quo_lo;
          // a zero denominator ends the expansion at once
          state_nxt = (quo_lo == '0) ? S_FIN : S_DR_GO;
        end
      end
      S_DR_GO: begin
        state_nxt = S_DR_WAIT;
      end
      S_DR_WAIT: begin
        if (div_sts.done) begin
          r_nxt = quo_lo;
          if (period_r != PERIOD_MAX) begin
            period_nxt = period_r + PERIOD_W'(1);
          end
          if (quo_lo == DW'(1)) begin
            run_nxt = run_inc;
            if (run_inc > best_r) begin
              best_nxt = run_inc;
            end
          end else begin
            run_nxt = '0;
          end
          state_nxt = (z_r == DW'(1)) ? S_FIN : S_MULA;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    r_r      <= r_nxt;
    num_r    <= num_nxt;
    sq_r     <= sq_nxt;
    period_r <= period_nxt;
    run_r    <= run_nxt;
    best_r   <= best_nxt;
    if (out_load) begin
      out_hit_r    <= !sq_r && (best_r >= cfg_r);
      out_sq_r     <= sq_r;
      out_period_r <= period_r;
      out_run_r    <= best_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_is_square     = out_sq_r;
  assign out_period_length = out_period_r;
  assign out_longest_run   = out_run_r;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the square-root continued-fraction run-of-ones
// test unit. A driver and a monitor run as clocked processes. The driver
// takes candidates from a pending queue and works in random bursts. Each
// transfer it makes is predicted at once against the bench's copy of the
// run-length register. The monitor checks every result transfer in order
// while the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top
  import scft_pkg::*;
();

  localparam int QUOT_CYCLES = 2 * CAND_W + 6;
  localparam int HOLD_CYCLES = 6000;
  localparam int ITEM_SLACK  = 120;
  localparam int PHASE_ITEMS = 38;
  localparam logic [CAND_W-1:0] CAND_MAX = {CAND_W{1'b1}};
  localparam logic [CFG_W-1:0] NEED_SET [6] = '{8'd0, 8'd255, 8'd2, 8'd3, 8'd1, 8'd4};

  typedef struct packed {
    logic                hit;
    logic                is_square;
    logic [PERIOD_W-1:0] period_length;
    logic [RUN_W-1:0]    longest_run;
  } cf_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CAND_W-1:0]   in_candidate = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic                out_is_square;
  logic [PERIOD_W-1:0] out_period_length;
  logic [RUN_W-1:0]    out_longest_run;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;

  logic [CAND_W-1:0] cand_q[$];
  cf_result_t        result_q[$];
  logic [CFG_W-1:0]  run_need = CFG_RESET;
  int unsigned       errors = 0;
  longint unsigned   cycles = 0;
  longint unsigned   budget = 0;
  int unsigned       burst_left = 1;
  int unsigned       gap_left = 0;
  int unsigned       hold_left = 0;
  int unsigned       press_req = 0;
  int unsigned       press_seen = 0;
  logic [31:0]       stall_pat = '0;
  int unsigned       pat_age = 0;

  sqrt_cfrac_ones_run_test_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_candidate      (in_candidate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_is_square     (out_is_square),
    .out_period_length (out_period_length),
    .out_longest_run   (out_longest_run),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expansion of sqrt(k): period length and longest run of unit quotients.
  function automatic cf_result_t cf_predict(logic [CAND_W-1:0] cand,
                                            logic [CFG_W-1:0] need);
    longint unsigned k, root, trial, y, z, quot;
    longint unsigned period, run, best;
    cf_result_t res;
    k = cand;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= k) root = trial;
    end
    res = '0;
    if (root * root == k) begin
      res.is_square = 1'b1;
      return res;
    end
    y = root;
    z = 1;
    quot = 2 * root;
    period = 0;
    run = 0;
    best = 0;
    do begin
      y = quot * z - y;
      z = (k - y * y) / z;
      quot = (root + y) / z;
      if (period < PERIOD_MAX) period++;
      if (quot == 1) begin
        if (run < RUN_MAX) run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end while (z != 1);
    res.hit           = (best >= need);
    res.period_length = period[PERIOD_W-1:0];
    res.longest_run   = best[RUN_W-1:0];
    return res;
  endfunction

  // Mostly small keys; large ones only in forms with a short period.
  function automatic logic [CAND_W-1:0] random_cand();
    longint unsigned n;
    int unsigned sel;
    n = $urandom_range(2, 46340);
    sel = $urandom_range(0, 19);
    if (sel < 12) return CAND_W'($urandom_range(0, 1500));
    if (sel < 15) return CAND_W'($urandom_range(1500, 20000));
    case ($urandom_range(0, 5))
      0: return CAND_W'(n * n);
      1: return CAND_W'(n * n + 1);
      2: return CAND_W'(n * n + 2);
      3: return CAND_W'(n * n - 1);
      4: return CAND_W'(n * n - 2);
      default: return CAND_W'(n * n + n);
    endcase
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    // cap the log, keep counting
    if (errors <= 200)
      $display("mismatch on %s: got %0d, expected %0d at cycle %0d",
               what, got, want, cycles);
  endtask

  task automatic queue_cand(logic [CAND_W-1:0] cand);
    cf_result_t res;
    cand_q.insert(cand_q.size(), cand);
    res = cf_predict(cand, run_need);
    budget += longint'(res.period_length) * QUOT_CYCLES + ITEM_SLACK;
  endtask

  task automatic set_need(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    run_need = value;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cand_q.size() != 0 || result_q.size() != 0 || in_valid);
    repeat (8) @(negedge clk);
  endtask

  // Driver: predict each transfer, then offer the next pending candidate.
  always @(posedge clk) begin
    logic [CAND_W-1:0] taken_cand;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken_cand = cand_q.pop_front();
        result_q.insert(result_q.size(), cf_predict(taken_cand, run_need));
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cand_q.size() > 0) begin
        in_valid     <= 1'b1;
        in_candidate <= cand_q[0];
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a rotating stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (press_req != press_seen) begin
      press_seen = press_req;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom & $urandom;
          default: stall_pat = $urandom | $urandom;
        endcase
        pat_age = 48;
      end
      pat_age--;
      out_stall <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    cf_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report("unexpected result", out_period_length, 0);
      end else begin
        want = result_q.pop_front();
        if (out_hit !== want.hit) report("hit", out_hit, want.hit);
        if (out_is_square !== want.is_square)
          report("is_square", out_is_square, want.is_square);
        if (out_period_length !== want.period_length)
          report("period_length", out_period_length, want.period_length);
        if (out_longest_run !== want.longest_run)
          report("longest_run", out_longest_run, want.longest_run);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4 * budget + 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cf_result_t top_res;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass with the register at its reset value: zero and one,
    // squares at both ends, short periods near the top of the key range.
    queue_cand(0);
    queue_cand(1);
    queue_cand(2);
    queue_cand(3);
    queue_cand(4);
    queue_cand(7);
    queue_cand(13);
    queue_cand(31'd1 << 30);
    queue_cand((31'd1 << 30) - 1);
    queue_cand((31'd1 << 30) + 1);
    queue_cand(31'd2147395600);
    queue_cand(31'd2147395599);
    queue_cand(31'd2147395601);
    queue_cand(31'd2147395602);
    queue_cand(31'd2147395598);
    queue_cand(31'd2147441940);
    queue_cand(31'd1431655765);
    // full-scale key only when its period stays short enough to simulate
    top_res = cf_predict(CAND_MAX, run_need);
    if (top_res.period_length <= 3000)
      queue_cand(CAND_MAX);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      set_need(p < 6 ? NEED_SET[p] : CFG_W'($urandom_range(1, 6)));
      if (p == 1) begin
        // quick keys so the unit fills up behind the hold-off
        press_req++;
        budget += HOLD_CYCLES;
        repeat (10) queue_cand(CAND_W'($urandom_range(0, 300)));
      end
      repeat (PHASE_ITEMS) queue_cand(random_cand());
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
design/scft_pkg.sv
design/scft_div.sv
design/sqrt_cfrac_ones_run_test_unit.sv
tb/sv/tb_top.sv
